// ===== rtl/scrs_pkg.sv =====
// Shared types, constants and digit functions of the small-coefficient sampler.
// Used by scrs_front, scrs_back and small_coefficient_rejection_sampler_top.
package scrs_pkg;

  localparam int MAX_COEFFS = 256;
  localparam int QDEPTH     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_ETA_MODE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_TARGET = 1'b1;

  localparam logic [7:0] BASE3_LIMIT = 8'd243;
  localparam logic [3:0] NIB_REJECT  = 4'hf;
  localparam logic [2:0] BASE3_DIGITS = 3'd5;

  typedef struct packed {
    logic       mode;
    logic [7:0] t;
    logic [2:0] ncand;
    logic       fin;
  } entry_t;

  typedef struct packed {
    logic [2:0] coefficient;
    logic       coeff_valid;
    logic [8:0] produced_count;
    logic       target_reached;
    logic       last_of_run;
  } result_t;

  function automatic logic [8:0] clamp_target(logic [8:0] v);
    if (int'(v) > MAX_COEFFS) begin
      return 9'(MAX_COEFFS);
    end
    return v;
  endfunction

  function automatic logic [2:0] balance3(logic [4:0] r);
    logic signed [5:0] v;
    v = $signed({1'b0, r}) - 6'sd3 * $signed({2'b0, r[4:1]});
    return v[2:0];
  endfunction

  function automatic logic [4:0] fold2(logic [4:0] r);
    return 5'({2'b0, r[4:2]} + {3'b0, r[1:0]});
  endfunction

  function automatic logic [4:0] nib_fold(logic [7:0] t);
    return 5'({1'b0, t[7:4]} + {1'b0, t[3:0]});
  endfunction

  function automatic logic [2:0] fold3_full(logic [7:0] t);
    return balance3(fold2(fold2(fold2(nib_fold(t)))));
  endfunction

  function automatic logic [2:0] fold3_26(logic [7:0] t);
    return balance3(fold2(fold2(nib_fold(t))));
  endfunction

  function automatic logic [2:0] fold3_8(logic [7:0] t);
    logic [6:0] r;
    logic [4:0] s;
    r = {1'b0, t[7:2]} + {5'b0, t[1:0]};
    s = 5'({2'b0, r[6:2]} + {5'b0, r[1:0]});
    return balance3(s);
  endfunction

  function automatic logic [2:0] nib_coef(logic [3:0] n);
    logic [3:0] m;
    if (n >= 4'd10) begin
      m = n - 4'd10;
    end else if (n >= 4'd5) begin
      m = n - 4'd5;
    end else begin
      m = n;
    end
    return 3'(4'd2 - m);
  endfunction

endpackage

// ===== rtl/small_coefficient_rejection_sampler_top.sv =====
// Top level of the small-coefficient rejection sampler.
// Depends on scrs_pkg, scrs_front and scrs_back.
//
// Random bytes enter on the slave stream, one per transaction; tlast marks the
// last byte of a buffer, after whose results the coefficient count returns to 0.
// Each byte gives one to five result transactions on the master stream: one per
// coefficient produced, or a single transaction with tuser low when the byte is
// rejected or the target count is already met. tlast marks a byte's last result.
// The config port sets the mode (base-3 digits or nibble mod 5) and the target.
// An accepted byte is stored in the queue, then its first result in the output
// register. Results leave at one per cycle while the receiver is ready; the
// single expansion sequencer in the back end sets this rate.
// A two-entry queue decouples input from expansion, so bytes keep flowing in
// while results wait; when the receiver stalls, the output register holds and
// the queue fills, then tready drops. Reset clears the count, empties the queue
// and restores base-3 mode with a target of 256.
module small_coefficient_rejection_sampler_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [7:0]                        s_axis_tdata_i,  // [7:0] random_byte
  input  logic                              s_axis_tlast_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [2:0] coefficient, [11:3] produced_count, [12] target_reached, [15:13] zero
  output logic [15:0]                       m_axis_tdata_o,
  output logic                              m_axis_tuser_o,  // [0] coeff_valid
  output logic                              m_axis_tlast_o,
  input  logic                              cfg_we_i,
  input  logic [scrs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [scrs_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import scrs_pkg::*;

  logic       eta_mode_q;
  logic [8:0] target_q;
  logic       entry_valid, pop;
  entry_t     entry;
  result_t    res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eta_mode_q <= 1'b0;
      target_q   <= clamp_target(9'd256);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ETA_MODE:     eta_mode_q <= cfg_wdata_i[0];
        REG_COEFF_TARGET: target_q   <= clamp_target(cfg_wdata_i[8:0]);
        default:          ;
      endcase
    end
  end

  scrs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (eta_mode_q),
    .s_tvalid_i    (s_axis_tvalid_i),
    .s_tready_o    (s_axis_tready_o),
    .byte_i        (s_axis_tdata_i),
    .final_i       (s_axis_tlast_i),
    .entry_valid_o (entry_valid),
    .entry_o       (entry),
    .pop_i         (pop)
  );

  scrs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .target_i      (target_q),
    .entry_valid_i (entry_valid),
    .entry_i       (entry),
    .pop_o         (pop),
    .m_tvalid_o    (m_axis_tvalid_o),
    .m_tready_i    (m_axis_tready_i),
    .res_o         (res)
  );

  assign m_axis_tdata_o = {3'b000, res.target_reached, res.produced_count, res.coefficient};
  assign m_axis_tuser_o = res.coeff_valid;
  assign m_axis_tlast_o = res.last_of_run;

endmodule

// ===== rtl/scrs_front.sv =====
// Input side of the sampler: classifies each random byte and queues it.
// Depends on scrs_pkg for the queue entry type and rejection limits.
module scrs_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            mode_i,
  input  logic            s_tvalid_i,
  output logic            s_tready_o,
  input  logic [7:0]      byte_i,
  input  logic            final_i,
  output logic            entry_valid_o,
  output scrs_pkg::entry_t entry_o,
  input  logic            pop_i
);
  import scrs_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  entry_t              mem_q [QDEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  entry_t              cls;
  logic                lo_ok, hi_ok, push, pop;

  always_comb begin
    lo_ok     = byte_i[3:0] != NIB_REJECT;
    hi_ok     = byte_i[7:4] != NIB_REJECT;
    cls.mode  = mode_i;
    cls.fin   = final_i;
    if (mode_i) begin
      cls.ncand = 3'({2'b0, lo_ok} + {2'b0, hi_ok});
      cls.t     = lo_ok ? byte_i : {4'b0, byte_i[7:4]};
    end else begin
      cls.ncand = (byte_i < BASE3_LIMIT) ? BASE3_DIGITS : 3'd0;
      cls.t     = byte_i;
    end
  end

  assign s_tready_o    = cnt_q != CNT_W'(QDEPTH);
  assign entry_valid_o = cnt_q != '0;
  assign entry_o       = mem_q[rd_ptr_q];
  assign push          = s_tvalid_i && s_tready_o;
  assign pop           = pop_i && entry_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (int'(wr_ptr_q) == QDEPTH - 1) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
    end
    if (pop) begin
      rd_ptr_d = (int'(rd_ptr_q) == QDEPTH - 1) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
    end
    if (push && !pop) begin
      cnt_d = CNT_W'(cnt_q + 1'b1);
    end else if (pop && !push) begin
      cnt_d = CNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ===== rtl/scrs_back.sv =====
// Output side of the sampler: expands queued bytes into coefficients, one per cycle unless the output stalls.
// Depends on scrs_pkg for entry and result types and the digit functions.
module scrs_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [8:0]       target_i,
  input  logic             entry_valid_i,
  input  scrs_pkg::entry_t entry_i,
  output logic             pop_o,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output scrs_pkg::result_t res_o
);
  import scrs_pkg::*;

  logic       busy_q;
  entry_t     work_q;
  logic [2:0] stage_q;
  logic [8:0] count_q, count_d;
  logic       out_valid_q;
  result_t    res_q, res_d;

  entry_t     src, nxt;
  logic [2:0] stage;
  logic       have_work, adv, fire, invalid, last;
  logic [2:0] digit;
  logic [8:0] cnt_inc, shown;
  logic [15:0] prod;

  always_comb begin
    src       = busy_q ? work_q : entry_i;
    stage     = busy_q ? stage_q : 3'd0;
    have_work = busy_q || entry_valid_i;
    adv       = !out_valid_q || m_tready_i;
    fire      = adv && have_work;
    invalid   = !busy_q && ((count_q >= target_i) || (src.ncand == 3'd0));
    cnt_inc   = count_q + 9'd1;
    last      = invalid || (3'(stage + 3'd1) == src.ncand) || (cnt_inc == target_i);

    if (src.mode) begin
      digit = nib_coef(src.t[3:0]);
    end else begin
      unique case (stage)
        3'd0, 3'd1: digit = fold3_full(src.t);
        3'd2:       digit = fold3_26(src.t);
        3'd3:       digit = fold3_8(src.t);
        default:    digit = balance3(src.t[4:0]);
      endcase
    end

    prod  = {8'b0, src.t} * 16'd171;
    nxt   = src;
    nxt.t = src.mode ? {4'b0, src.t[7:4]} : 8'(prod >> 9);

    shown                = invalid ? count_q : cnt_inc;
    res_d.coefficient    = invalid ? 3'd0 : digit;
    res_d.coeff_valid    = !invalid;
    res_d.produced_count = shown;
    res_d.target_reached = shown == target_i;
    res_d.last_of_run    = last;

    count_d = count_q;
    if (last && src.fin) begin
      count_d = '0;
    end else if (!invalid) begin
      count_d = cnt_inc;
    end
  end

  assign pop_o      = fire && !busy_q;
  assign m_tvalid_o = out_valid_q;
  assign res_o      = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      stage_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
      count_q     <= count_d;
      busy_q      <= !last;
      stage_q     <= 3'(stage + 3'd1);
    end else if (adv) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q  <= res_d;
      work_q <= nxt;
    end
  end

  a_invalid_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.coeff_valid) |-> res_q.last_of_run)
    else $error("invalid result not marked last");

  a_stage_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (stage_q != 3'd0 && stage_q < work_q.ncand))
    else $error("expansion stage out of range");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && last && src.fin) |=> (count_q == 9'd0 && !busy_q))
    else $error("count not cleared after final byte");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !pop_o)
    else $error("queue popped during expansion");

endmodule
